@@ hdl/tsd_pkg.sv @@
// Package for the two-sensor tray debounce block: state codes, register map and config type.
package tsd_pkg;

  // Width of the seconds timestamp and of the elapsed-time difference.
  localparam int unsigned TIME_W = 32;

  // The configuration port decodes five word registers.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_RESTART = 3'd1;
  localparam logic [2:0] REG_SETTLE  = 3'd2;
  localparam logic [2:0] REG_CHECK   = 3'd3;
  localparam logic [2:0] REG_ERROR   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0] SETTLE_RST = 8'd4;
  localparam logic [7:0] CHECK_RST  = 8'd15;
  localparam logic [7:0] ERROR_RST  = 8'd5;

  // Tray state and pattern class codes.
  typedef enum logic [1:0] {
    ST_UNLOADED = 2'd0,
    ST_LOADED   = 2'd1,
    ST_MOVING   = 2'd2,
    ST_CHECK    = 2'd3
  } tray_state_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic       enable;
    logic       restart_on_change;
    logic [7:0] settle_seconds;
    logic [7:0] check_seconds;
    logic [7:0] error_seconds;
  } cfg_t;

endpackage

@@ hdl/tsd_in_if.sv @@
// Interfaces for the sensor poll channel and the tray result channel.
interface tsd_in_if;
  logic        valid;
  logic        ready;
  logic        sensor_a;
  logic        sensor_b;
  logic [31:0] now_seconds;
  logic        check_ack;

  modport source (output valid, sensor_a, sensor_b, now_seconds, check_ack, input ready);
  modport sink   (input valid, sensor_a, sensor_b, now_seconds, check_ack, output ready);
endinterface

interface tsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] tray_state;
  logic       check_request;
  logic       direction_fault;
  logic       state_changed;

  modport source (output valid, tray_state, check_request, direction_fault, state_changed,
                  input ready);
  modport sink   (input valid, tray_state, check_request, direction_fault, state_changed,
                  output ready);
endinterface

@@ hdl/two_sensor_tray_debounce_top.sv @@
// Top level of the two-sensor tray debounce block.
// Each poll beat is evaluated in the cycle it is accepted, against the stored pattern class,
// confirmed state and timestamp, and its result lands in a one-deep output register: the
// block takes one poll per clock, and the only stall comes from that output register when
// it is full and not being taken. Pattern a=1,b=0 is the load pattern and a=0,b=0 the
// unload pattern; either must hold settle_seconds to be confirmed. A mixed pattern held
// check_seconds raises a check request; after the host acknowledges, a mixed pattern held
// error_seconds raises a direction fault and reports moving. With enable low the block
// reports loaded with no pulses. Elapsed time is the timestamp difference modulo 2^32 read
// as signed, so a timestamp that goes backward never fires a timeout.
module two_sensor_tray_debounce_top (
  input  logic                       clk,
  input  logic                       rst_n,
  tsd_in_if.sink                     in_ch,
  tsd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsd_pkg::ADDR_W-1:0] paddr,
  input  logic [tsd_pkg::DATA_W-1:0] pwdata,
  output logic [tsd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  tsd_pkg::cfg_t cfg;

  tsd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Debounce state.
  tsd_pkg::tray_state_t        raw_r, raw_nxt;
  tsd_pkg::tray_state_t        prev_r, prev_nxt;
  tsd_pkg::tray_state_t        conf_r, conf_nxt;
  tsd_pkg::tray_state_t        shown_r, shown_nxt;
  logic [tsd_pkg::TIME_W-1:0]  stamp_r, stamp_nxt;
  logic                        cc_r, cc_nxt;

  // Output register.
  logic                        out_valid_r;
  logic [1:0]                  out_state_r;
  logic                        out_req_r, out_fault_r, out_chg_r;
  logic                        req_nxt, fault_nxt, chg_nxt;

  logic                        in_acc;
  logic [tsd_pkg::TIME_W-1:0]  now;
  logic [tsd_pkg::TIME_W-1:0]  diff;
  logic                        ahead;
  logic                        settle_hit, check_hit, error_hit;
  tsd_pkg::tray_state_t        target;

  // A new beat enters whenever the output register is empty or drains this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign now         = in_ch.now_seconds;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.tray_state      = out_state_r;
  assign out_ch.check_request   = out_req_r;
  assign out_ch.direction_fault = out_fault_r;
  assign out_ch.state_changed   = out_chg_r;

  // Timer restart on a class change comes first; the timeouts see the restarted stamp.
  always_comb begin
    prev_nxt  = prev_r;
    stamp_nxt = stamp_r;
    if (cfg.enable && cfg.restart_on_change && (raw_r != prev_r)) begin
      prev_nxt  = raw_r;
      stamp_nxt = now;
    end
  end

  // Elapsed time as a signed difference; negative never reaches a threshold.
  assign diff       = now - stamp_nxt;
  assign ahead      = !diff[tsd_pkg::TIME_W-1];
  assign settle_hit = ahead && (diff >= {{(tsd_pkg::TIME_W-8){1'b0}}, cfg.settle_seconds});
  assign check_hit  = ahead && (diff >= {{(tsd_pkg::TIME_W-8){1'b0}}, cfg.check_seconds});
  assign error_hit  = ahead && (diff >= {{(tsd_pkg::TIME_W-8){1'b0}}, cfg.error_seconds});
  assign target     = in_ch.sensor_a ? tsd_pkg::ST_LOADED : tsd_pkg::ST_UNLOADED;

  // Pattern classification and the confirm, check and fault decisions.
  logic [tsd_pkg::TIME_W-1:0] stamp_fin;
  always_comb begin
    raw_nxt   = raw_r;
    conf_nxt  = conf_r;
    shown_nxt = shown_r;
    cc_nxt    = cc_r || in_ch.check_ack;
    stamp_fin = stamp_nxt;
    req_nxt   = 1'b0;
    fault_nxt = 1'b0;
    chg_nxt   = 1'b0;
    if (!cfg.enable) begin
      shown_nxt = tsd_pkg::ST_LOADED;
    end else if (!in_ch.sensor_b) begin
      raw_nxt = target;
      if (conf_r != target) begin
        if (settle_hit) begin
          conf_nxt  = target;
          shown_nxt = target;
          cc_nxt    = 1'b0;
          chg_nxt   = 1'b1;
        end
      end else begin
        stamp_fin = now;
      end
    end else if (!cc_nxt) begin
      raw_nxt = tsd_pkg::ST_MOVING;
      if (conf_r != tsd_pkg::ST_MOVING && conf_r != tsd_pkg::ST_CHECK) begin
        if (check_hit) begin
          raw_nxt   = tsd_pkg::ST_CHECK;
          conf_nxt  = tsd_pkg::ST_CHECK;
          shown_nxt = tsd_pkg::ST_CHECK;
          req_nxt   = 1'b1;
        end
      end else begin
        stamp_fin = now;
      end
    end else if (error_hit) begin
      conf_nxt  = tsd_pkg::ST_MOVING;
      shown_nxt = tsd_pkg::ST_MOVING;
      cc_nxt    = 1'b0;
      fault_nxt = 1'b1;
    end
  end

  // State update on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r   <= tsd_pkg::ST_UNLOADED;
      prev_r  <= tsd_pkg::ST_UNLOADED;
      conf_r  <= tsd_pkg::ST_UNLOADED;
      shown_r <= tsd_pkg::ST_UNLOADED;
      stamp_r <= '0;
      cc_r    <= 1'b0;
    end else if (in_acc) begin
      raw_r   <= raw_nxt;
      prev_r  <= prev_nxt;
      conf_r  <= conf_nxt;
      shown_r <= shown_nxt;
      stamp_r <= stamp_fin;
      cc_r    <= cc_nxt;
    end
  end

  // Result register: loaded on accept, emptied when taken with nothing behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_state_r <= shown_nxt;
      out_req_r   <= req_nxt;
      out_fault_r <= fault_nxt;
      out_chg_r   <= chg_nxt;
    end
  end

`ifndef SYNTHESIS
  // At most one event pulse per result beat.
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_req_r, out_fault_r, out_chg_r}))
    else $error("more than one event pulse in a result beat");

  // Each pulse comes with the state it reports.
  a_pulse_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_req_r || out_state_r == tsd_pkg::ST_CHECK) &&
                     (!out_fault_r || out_state_r == tsd_pkg::ST_MOVING) &&
                     (!out_chg_r || out_state_r == tsd_pkg::ST_LOADED ||
                      out_state_r == tsd_pkg::ST_UNLOADED)))
    else $error("event pulse disagrees with reported state");

  // A poll taken while disabled reports loaded with no events.
  a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg.enable) |=> (out_valid_r && out_state_r == tsd_pkg::ST_LOADED &&
                                 !out_req_r && !out_fault_r && !out_chg_r))
    else $error("disabled poll did not report loaded");

  // The check state is only ever confirmed with the completion flag clear.
  a_check_cc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && req_nxt) |=> !cc_r)
    else $error("check request raised with check already complete");
`endif

endmodule

@@ hdl/tsd_regs.sv @@
// APB-style configuration register bank for the tray debounce block.
module tsd_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsd_pkg::ADDR_W-1:0] paddr,
  input  logic [tsd_pkg::DATA_W-1:0] pwdata,
  output logic [tsd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tsd_pkg::cfg_t              cfg
);

  tsd_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable            <= 1'b1;
      cfg_r.restart_on_change <= 1'b1;
      cfg_r.settle_seconds    <= tsd_pkg::SETTLE_RST;
      cfg_r.check_seconds     <= tsd_pkg::CHECK_RST;
      cfg_r.error_seconds     <= tsd_pkg::ERROR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        tsd_pkg::REG_ENABLE:  cfg_r.enable            <= pwdata[0];
        tsd_pkg::REG_RESTART: cfg_r.restart_on_change <= pwdata[0];
        tsd_pkg::REG_SETTLE:  cfg_r.settle_seconds    <= pwdata[7:0];
        tsd_pkg::REG_CHECK:   cfg_r.check_seconds     <= pwdata[7:0];
        tsd_pkg::REG_ERROR:   cfg_r.error_seconds     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      tsd_pkg::REG_ENABLE:  prdata[0]   = cfg_r.enable;
      tsd_pkg::REG_RESTART: prdata[0]   = cfg_r.restart_on_change;
      tsd_pkg::REG_SETTLE:  prdata[7:0] = cfg_r.settle_seconds;
      tsd_pkg::REG_CHECK:   prdata[7:0] = cfg_r.check_seconds;
      tsd_pkg::REG_ERROR:   prdata[7:0] = cfg_r.error_seconds;
      default:              prdata      = '0;
    endcase
  end

endmodule

@@ dv/tsd_tray_compare.sv @@
// Tray debounce checker: watches the poll, result and register ports, predicts and compares.
module tsd_tray_compare (
  input  logic                       clk,
  input  logic                       rst_n,
  tsd_in_if                          in_ch,
  tsd_out_if                         out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsd_pkg::ADDR_W-1:0] paddr,
  input  logic [tsd_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int unsigned                fail_count,
  output int unsigned                pending,
  output int unsigned                polls,
  output int unsigned                confirms,
  output int unsigned                checks,
  output int unsigned                faults
);
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result beat.
  typedef struct packed {
    tsd_pkg::tray_state_t tray;
    logic                 req;
    logic                 fault;
    logic                 changed;
  } tray_result_t;

  tray_result_t expected_trays[$];

  // Shadow of the configuration registers, tracked from the register port.
  tsd_pkg::cfg_t cfg;

  // Shadow of the debounce state.
  tsd_pkg::tray_state_t        raw_cls;
  tsd_pkg::tray_state_t        prev_cls;
  tsd_pkg::tray_state_t        conf_st;
  tsd_pkg::tray_state_t        shown;
  logic [tsd_pkg::TIME_W-1:0]  stamp;
  logic                        ack_seen;

  // True when the time since the stamp is non-negative and reaches the limit.
  function automatic logic held_for(logic [tsd_pkg::TIME_W-1:0] now, logic [7:0] limit);
    logic [tsd_pkg::TIME_W-1:0] diff;
    diff = now - stamp;
    return !diff[tsd_pkg::TIME_W-1] && (diff >= tsd_pkg::TIME_W'(limit));
  endfunction

  // Advances the shadow state by one poll and returns the result it should produce.
  function automatic tray_result_t debounce_poll(logic a, logic b,
                                                 logic [tsd_pkg::TIME_W-1:0] now,
                                                 logic ack);
    tray_result_t         r;
    tsd_pkg::tray_state_t target;
    r.req     = 1'b0;
    r.fault   = 1'b0;
    r.changed = 1'b0;
    if (ack) begin
      ack_seen = 1'b1;
    end
    if (!cfg.enable) begin
      shown = tsd_pkg::ST_LOADED;
    end else begin
      if (cfg.restart_on_change && raw_cls != prev_cls) begin
        prev_cls = raw_cls;
        stamp    = now;
      end
      if (!b) begin
        // Load or unload pattern: confirm once it has held long enough.
        if (a) begin
          target = tsd_pkg::ST_LOADED;
        end else begin
          target = tsd_pkg::ST_UNLOADED;
        end
        raw_cls = target;
        if (conf_st != target) begin
          if (held_for(now, cfg.settle_seconds)) begin
            conf_st   = target;
            shown     = target;
            ack_seen  = 1'b0;
            r.changed = 1'b1;
          end
        end else begin
          stamp = now;
        end
      end else if (!ack_seen) begin
        // Mixed pattern before acknowledgement: may raise a check request.
        raw_cls = tsd_pkg::ST_MOVING;
        if (conf_st != tsd_pkg::ST_MOVING && conf_st != tsd_pkg::ST_CHECK) begin
          if (held_for(now, cfg.check_seconds)) begin
            raw_cls = tsd_pkg::ST_CHECK;
            conf_st = tsd_pkg::ST_CHECK;
            shown   = tsd_pkg::ST_CHECK;
            r.req   = 1'b1;
          end
        end else begin
          stamp = now;
        end
      end else if (held_for(now, cfg.error_seconds)) begin
        // Mixed pattern after acknowledgement: direction fault.
        conf_st  = tsd_pkg::ST_MOVING;
        shown    = tsd_pkg::ST_MOVING;
        ack_seen = 1'b0;
        r.fault  = 1'b1;
      end
    end
    r.tray = shown;
    return r;
  endfunction

  // Compares one field and reports a difference.
  task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Register writes, result beats and poll beats, all sampled at the rising edge.
  always @(posedge clk) begin
    tray_result_t want;
    if (!rst_n) begin
      cfg.enable            = 1'b1;
      cfg.restart_on_change = 1'b1;
      cfg.settle_seconds    = tsd_pkg::SETTLE_RST;
      cfg.check_seconds     = tsd_pkg::CHECK_RST;
      cfg.error_seconds     = tsd_pkg::ERROR_RST;
      raw_cls    = tsd_pkg::ST_UNLOADED;
      prev_cls   = tsd_pkg::ST_UNLOADED;
      conf_st    = tsd_pkg::ST_UNLOADED;
      shown      = tsd_pkg::ST_UNLOADED;
      stamp      = '0;
      ack_seen   = 1'b0;
      expected_trays.delete();
      fail_count = 0;
      polls      = 0;
      confirms   = 0;
      checks     = 0;
      faults     = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[tsd_pkg::ADDR_W-1:2])
          tsd_pkg::REG_ENABLE:  cfg.enable            = pwdata[0];
          tsd_pkg::REG_RESTART: cfg.restart_on_change = pwdata[0];
          tsd_pkg::REG_SETTLE:  cfg.settle_seconds    = pwdata[7:0];
          tsd_pkg::REG_CHECK:   cfg.check_seconds     = pwdata[7:0];
          tsd_pkg::REG_ERROR:   cfg.error_seconds     = pwdata[7:0];
          default: ;
        endcase
      end
      // A result beat comes from an earlier poll, so it is matched before this edge's poll.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_trays.size() == 0) begin
          fail_count++;
          $display("%0t: expected no result beat, actual tray_state %0d", $time,
                   out_ch.tray_state);
        end else begin
          want = expected_trays.pop_front();
          check_field("tray_state", want.tray, out_ch.tray_state);
          check_field("check_request", {1'b0, want.req}, {1'b0, out_ch.check_request});
          check_field("direction_fault", {1'b0, want.fault}, {1'b0, out_ch.direction_fault});
          check_field("state_changed", {1'b0, want.changed}, {1'b0, out_ch.state_changed});
          confirms += want.changed;
          checks   += want.req;
          faults   += want.fault;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_trays.push_back(debounce_poll(in_ch.sensor_a, in_ch.sensor_b,
                                               in_ch.now_seconds, in_ch.check_ack));
        polls++;
      end
    end
    pending = expected_trays.size();
  end

endmodule

@@ dv/tb_two_sensor_tray_debounce_top.sv @@
// Testbench top for the tray debounce block: clock, reset, register setup, polls and verdict.
module tb_two_sensor_tray_debounce_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 8;
  localparam int LONG_HOLD       = 300;

  logic                       clk;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [tsd_pkg::ADDR_W-1:0] paddr;
  logic [tsd_pkg::DATA_W-1:0] pwdata;
  logic [tsd_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned polls;
  int unsigned confirms;
  int unsigned checks;
  int unsigned faults;

  logic [tsd_pkg::TIME_W-1:0] clock_secs;
  bit                         long_hold_req;

  tsd_in_if  poll_ch ();
  tsd_out_if tray_ch ();

  two_sensor_tray_debounce_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (poll_ch),
    .out_ch  (tray_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tsd_tray_compare tray_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (poll_ch),
    .out_ch     (tray_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending),
    .polls      (polls),
    .confirms   (confirms),
    .checks     (checks),
    .faults     (faults)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic [2:0] idx, logic [tsd_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_config(bit en, bit restart, logic [7:0] settle, logic [7:0] chk_s,
                              logic [7:0] err_s);
    write_reg(tsd_pkg::REG_ENABLE, tsd_pkg::DATA_W'(en));
    write_reg(tsd_pkg::REG_RESTART, tsd_pkg::DATA_W'(restart));
    write_reg(tsd_pkg::REG_SETTLE, tsd_pkg::DATA_W'(settle));
    write_reg(tsd_pkg::REG_CHECK, tsd_pkg::DATA_W'(chk_s));
    write_reg(tsd_pkg::REG_ERROR, tsd_pkg::DATA_W'(err_s));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one poll beat after an optional gap and waits until it is taken.
  task automatic send_poll(logic a, logic b, logic [tsd_pkg::TIME_W-1:0] t, logic ack,
                           bit steady);
    int gap;
    gap = pick_gap(steady);
    @(negedge clk);
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    poll_ch.valid       <= 1'b1;
    poll_ch.sensor_a    <= a;
    poll_ch.sensor_b    <= b;
    poll_ch.now_seconds <= t;
    poll_ch.check_ack   <= ack;
    do @(posedge clk); while (!poll_ch.ready);
  endtask

  // Drops valid and waits until every expected result has come out.
  task automatic drain_results();
    @(negedge clk);
    poll_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Runs of one sensor pattern with a slowly advancing clock, mixed with short noisy runs.
  task automatic run_random_polls(int count, int step_max, bit steady);
    logic       a;
    logic       b;
    logic       ack;
    logic [1:0] pat;
    bit         noisy;
    int         run_left;
    run_left = 0;
    a = 1'b0;
    b = 1'b0;
    noisy = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (run_left == 0) begin
        noisy    = ($urandom_range(0, 99) < 15);
        run_left = noisy ? $urandom_range(1, 6) : $urandom_range(2, 30);
        pat      = 2'($urandom_range(0, 3));
        a        = pat[0];
        b        = pat[1];
      end
      if (noisy) begin
        a   = 1'($urandom_range(0, 1));
        b   = 1'($urandom_range(0, 1));
        ack = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0:       clock_secs = $urandom;
          1:       clock_secs -= $urandom_range(1, 50);
          default: clock_secs += $urandom_range(0, step_max);
        endcase
      end else begin
        ack = ($urandom_range(0, 19) == 0);
        clock_secs += $urandom_range(0, step_max);
      end
      send_poll(a, b, clock_secs, ack, steady);
      run_left--;
    end
  endtask

  // Result side: ready in runs and gaps, plus one long hold-off on request.
  initial begin
    int run_left;
    int gap_left;
    int hold_left;
    run_left  = 0;
    gap_left  = 0;
    hold_left = 0;
    tray_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        tray_ch.ready <= 1'b0;
      end else begin
        if (run_left == 0 && gap_left == 0) begin
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 8);
          gap_left = pick_gap(1'b0);
        end
        if (run_left > 0) begin
          run_left--;
          tray_ch.ready <= 1'b1;
        end else begin
          gap_left--;
          tray_ch.ready <= 1'b0;
        end
      end
    end
  end

  // Main sequence: reset, directed polls, then phases of random polls under several settings.
  initial begin
    bit         en;
    bit         restart;
    logic [7:0] settle;
    logic [7:0] chk_s;
    logic [7:0] err_s;
    int         step_max;
    bit         steady;

    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    poll_ch.valid       = 1'b0;
    poll_ch.sensor_a    = 1'b0;
    poll_ch.sensor_b    = 1'b0;
    poll_ch.now_seconds = '0;
    poll_ch.check_ack   = 1'b0;
    long_hold_req       = 1'b0;
    clock_secs          = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: load, mixed to check, acknowledge to fault, unload, wrap and backward time.
    send_poll(1'b0, 1'b0, 32'd0, 1'b0, 1'b0);
    send_poll(1'b1, 1'b0, 32'd1, 1'b0, 1'b0);
    send_poll(1'b1, 1'b0, 32'd2, 1'b0, 1'b0);
    send_poll(1'b1, 1'b0, 32'd8, 1'b0, 1'b0);
    send_poll(1'b1, 1'b0, 32'd9, 1'b0, 1'b0);
    send_poll(1'b0, 1'b1, 32'd10, 1'b0, 1'b0);
    send_poll(1'b0, 1'b1, 32'd11, 1'b0, 1'b0);
    send_poll(1'b0, 1'b1, 32'd40, 1'b0, 1'b0);
    send_poll(1'b1, 1'b1, 32'd41, 1'b1, 1'b0);
    send_poll(1'b1, 1'b1, 32'd42, 1'b0, 1'b0);
    send_poll(1'b1, 1'b1, 32'd60, 1'b0, 1'b0);
    send_poll(1'b1, 1'b1, 32'd61, 1'b0, 1'b0);
    send_poll(1'b0, 1'b0, 32'd62, 1'b0, 1'b0);
    send_poll(1'b0, 1'b0, 32'd100, 1'b0, 1'b0);
    send_poll(1'b0, 1'b0, 32'hFFFF_FFF0, 1'b0, 1'b0);
    send_poll(1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_poll(1'b1, 1'b0, 32'h0000_0003, 1'b0, 1'b0);
    send_poll(1'b1, 1'b0, 32'h0000_0010, 1'b0, 1'b0);
    send_poll(1'b1, 1'b0, 32'h0000_0001, 1'b1, 1'b0);
    send_poll(1'b0, 1'b0, 32'h8000_0000, 1'b0, 1'b0);
    send_poll(1'b0, 1'b0, 32'h8000_0010, 1'b0, 1'b0);
    send_poll(1'b0, 1'b1, 32'h8000_0020, 1'b1, 1'b0);
    send_poll(1'b0, 1'b1, 32'h8000_0030, 1'b0, 1'b0);
    drain_results();

    // Phase 0 keeps the reset settings; the others cover zero, maximum, disabled, fixed small values and random.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      en      = 1'b1;
      restart = 1'b1;
      settle  = tsd_pkg::SETTLE_RST;
      chk_s   = tsd_pkg::CHECK_RST;
      err_s   = tsd_pkg::ERROR_RST;
      case (ph)
        1: begin
          settle = 8'd0;
          chk_s  = 8'd0;
          err_s  = 8'd0;
        end
        2: begin
          restart = 1'b0;
          settle  = 8'd255;
          chk_s   = 8'd255;
          err_s   = 8'd255;
        end
        3: en = 1'b0;
        4: begin
          settle = 8'd2;
          chk_s  = 8'd6;
          err_s  = 8'd3;
        end
        5: begin
          restart = 1'b0;
          settle  = 8'd3;
          chk_s   = 8'd10;
          err_s   = 8'd2;
        end
        6, 7: begin
          en      = ($urandom_range(0, 4) != 0);
          restart = 1'($urandom_range(0, 1));
          settle  = 8'($urandom_range(0, 20));
          chk_s   = 8'($urandom_range(0, 40));
          err_s   = 8'($urandom_range(0, 20));
        end
        default: ;
      endcase
      if (ph > 0) begin
        apply_config(en, restart, settle, chk_s, err_s);
      end
      step_max = 2;
      if (settle / 5 + 2 > step_max) step_max = settle / 5 + 2;
      if (chk_s / 5 + 2 > step_max) step_max = chk_s / 5 + 2;
      if (err_s / 5 + 2 > step_max) step_max = err_s / 5 + 2;
      steady = (ph == 1 || ph == 4);
      // In this phase the result side stalls for a long stretch while polls keep coming.
      if (ph == 4) begin
        long_hold_req = 1'b1;
      end
      clock_secs = $urandom;
      run_random_polls(ITEMS_PER_PHASE, step_max, steady);
      drain_results();
    end

    repeat (4) @(negedge clk);
    $display("Covered %0d polls over %0d register settings, directed and random.",
             polls, NUM_PHASES);
    $display("Seen %0d load/unload confirmations, %0d check requests, %0d direction faults.",
             confirms, checks, faults);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
